// ----- hdl/ipmd_pkg.sv -----
package ipmd_pkg;

  // Fixed point and clamp settings
  localparam int GAIN_FRAC_BITS = 8;
  localparam int DRIVE_LIMIT    = 99;

  // Field widths
  localparam int E_W    = 16;              // error and encoder count
  localparam int G_W    = 16;              // gain, unsigned
  localparam int GX_W   = G_W + 1;         // gain as a signed operand
  localparam int DP_W   = E_W + 1;         // e - e1
  localparam int DD_W   = E_W + 2;         // e - 2*e1 + e2
  localparam int PP_W   = GX_W + DP_W;     // proportional product
  localparam int PI_W   = GX_W + E_W;      // integral product
  localparam int PD_W   = GX_W + DD_W;     // derivative product
  localparam int SUM_W  = PD_W + 2;        // sum of three products
  localparam int DRV_W  = 8;               // drive level
  localparam int DUTY_W = 7;               // duty outputs
  localparam int DSUM_W = E_W + 1;         // accumulator plus increment
  localparam int IDX_W  = 2;               // configuration index

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_TARGET_SPEED = 2'd0;
  localparam logic [IDX_W-1:0] REG_GAIN_P       = 2'd1;
  localparam logic [IDX_W-1:0] REG_GAIN_I       = 2'd2;
  localparam logic [IDX_W-1:0] REG_GAIN_D       = 2'd3;

  localparam logic signed [E_W-1:0] TARGET_RESET = 16'sd100;

  // Saturation limits
  localparam logic signed [E_W-1:0] E_MAX = 16'sh7fff;
  localparam logic signed [E_W-1:0] E_MIN = 16'sh8000;

  // Truncation toward zero: bias negative sums before the arithmetic shift
  localparam logic signed [SUM_W-1:0] RND_BIAS = SUM_W'((1 << GAIN_FRAC_BITS) - 1);

  localparam logic signed [DSUM_W-1:0] DRV_HI = DSUM_W'(DRIVE_LIMIT);
  localparam logic signed [DSUM_W-1:0] DRV_LO = -DRV_HI;

  typedef struct packed {
    logic signed [E_W-1:0] target_speed;
    logic [G_W-1:0]        gain_p;
    logic [G_W-1:0]        gain_i;
    logic [G_W-1:0]        gain_d;
  } ipmd_cfg_t;

  typedef struct packed {
    logic signed [PP_W-1:0] p_p;
    logic signed [PI_W-1:0] p_i;
    logic signed [PD_W-1:0] p_d;
  } ipmd_prod_t;

endpackage

// ----- hdl/ipmd_cfg_regs.sv -----
module ipmd_cfg_regs
  import ipmd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [G_W-1:0]   cfg_data,
  output ipmd_cfg_t        cfg
);

  ipmd_cfg_t cfg_r;

  // Register file writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_speed <= TARGET_RESET;
      cfg_r.gain_p       <= '0;
      cfg_r.gain_i       <= '0;
      cfg_r.gain_d       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TARGET_SPEED: cfg_r.target_speed <= $signed(cfg_data);
        REG_GAIN_P:       cfg_r.gain_p       <= cfg_data;
        REG_GAIN_I:       cfg_r.gain_i       <= cfg_data;
        REG_GAIN_D:       cfg_r.gain_d       <= cfg_data;
        default:          ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- hdl/ipmd_err_stage.sv -----
module ipmd_err_stage
  import ipmd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  ipmd_cfg_t             cfg,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [E_W-1:0] in_encoder_count,
  output logic                  prod_valid,
  output ipmd_prod_t            prod,
  input  logic                  prod_take
);

  logic                  s1_valid_r, s1_valid_nxt;
  logic signed [E_W-1:0] count_r;
  logic                  prod_valid_r, prod_valid_nxt;
  ipmd_prod_t            prod_r, prod_nxt;
  logic signed [E_W-1:0] e1_r, e2_r;

  logic                  s2_free, s1_adv, in_xfer;
  logic signed [DP_W-1:0] diff;
  logic signed [E_W-1:0] err;
  logic signed [DP_W-1:0] dp;
  logic signed [DD_W-1:0] dd;
  logic signed [GX_W-1:0] gp, gi, gd;

  // Stage handshake
  assign s2_free  = !prod_valid_r || prod_take;
  assign s1_adv   = s1_valid_r && s2_free;
  assign in_stall = s1_valid_r && !s2_free;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    prod_valid_nxt = prod_valid_r;
    if (s1_adv) begin
      prod_valid_nxt = 1'b1;
    end else if (prod_take) begin
      prod_valid_nxt = 1'b0;
    end
  end

  // Saturated error
  always_comb begin
    diff = DP_W'(cfg.target_speed) - DP_W'(count_r);
    if (diff[DP_W-1] != diff[DP_W-2]) begin
      err = diff[DP_W-1] ? E_MIN : E_MAX;
    end else begin
      err = diff[E_W-1:0];
    end
  end

  // Differences and gain products
  always_comb begin
    dp = DP_W'(err) - DP_W'(e1_r);
    dd = DD_W'(err) - (DD_W'(e1_r) <<< 1) + DD_W'(e2_r);
    gp = $signed({1'b0, cfg.gain_p});
    gi = $signed({1'b0, cfg.gain_i});
    gd = $signed({1'b0, cfg.gain_d});
    prod_nxt.p_p = PP_W'(gp) * PP_W'(dp);
    prod_nxt.p_i = PI_W'(gi) * PI_W'(err);
    prod_nxt.p_d = PD_W'(gd) * PD_W'(dd);
  end

  // Control and error history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      prod_valid_r <= 1'b0;
      e1_r         <= '0;
      e2_r         <= '0;
    end else begin
      s1_valid_r   <= s1_valid_nxt;
      prod_valid_r <= prod_valid_nxt;
      if (s1_adv) begin
        e1_r <= err;
        e2_r <= e1_r;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      count_r <= in_encoder_count;
    end
    if (s1_adv) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod_valid = prod_valid_r;
  assign prod       = prod_r;

endmodule

// ----- hdl/ipmd_acc_stage.sv -----
module ipmd_acc_stage
  import ipmd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    prod_valid,
  input  ipmd_prod_t              prod,
  output logic                    prod_take,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [DRV_W-1:0] out_drive_level,
  output logic [DUTY_W-1:0]       out_forward_duty,
  output logic [DUTY_W-1:0]       out_backward_duty
);

  logic                    out_valid_r, out_valid_nxt;
  logic signed [DRV_W-1:0] acc_r, acc_nxt;
  logic                    load;
  logic signed [SUM_W-1:0] sum, sum_adj, shifted;
  logic signed [E_W-1:0]   inc;
  logic signed [DSUM_W-1:0] dsum;
  logic [DRV_W-1:0]        neg_drive;

  // Output register takes a new transfer when empty or being drained
  assign prod_take = !out_valid_r || !out_stall;
  assign load      = prod_valid && prod_take;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Product sum, shift toward zero, saturate
  always_comb begin
    sum     = SUM_W'(prod.p_p) + SUM_W'(prod.p_i) + SUM_W'(prod.p_d);
    sum_adj = sum[SUM_W-1] ? (sum + RND_BIAS) : sum;
    shifted = sum_adj >>> GAIN_FRAC_BITS;
    if (shifted[SUM_W-1:E_W-1] != {(SUM_W-E_W+1){shifted[SUM_W-1]}}) begin
      inc = shifted[SUM_W-1] ? E_MIN : E_MAX;
    end else begin
      inc = shifted[E_W-1:0];
    end
  end

  // Accumulate and clamp the drive
  always_comb begin
    dsum = DSUM_W'(acc_r) + DSUM_W'(inc);
    priority if (dsum > DRV_HI) begin
      acc_nxt = DRV_W'(DRV_HI);
    end else if (dsum < DRV_LO) begin
      acc_nxt = DRV_W'(DRV_LO);
    end else begin
      acc_nxt = dsum[DRV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      acc_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (load) begin
        acc_r <= acc_nxt;
      end
    end
  end

  // H-bridge split of the held drive
  assign neg_drive         = DRV_W'(0) - acc_r;
  assign out_valid         = out_valid_r;
  assign out_drive_level   = acc_r;
  assign out_forward_duty  = (acc_r > 0) ? acc_r[DUTY_W-1:0] : '0;
  assign out_backward_duty = (acc_r > 0) ? '0 : neg_drive[DUTY_W-1:0];

endmodule

// ----- hdl/incremental_pid_motor_drive_core.sv -----
// Channel   Direction  Handshake        Payload
// in_       input      valid / stall    encoder_count (16 signed)
// out_      output     valid / stall    drive_level (8 signed), forward_duty (7),
//                                       backward_duty (7)
// cfg_      input      we (no wait)     index (2), data (16)
//
// One item per cycle sustained while out_stall is low; after the input transfer, the
// item passes the input register, product register and drive register in turn, and
// out_valid rises once the drive register holds it.
// The drive accumulator closes its loop within the final stage.
// rst_n is synchronous: clears history, drive and config to reset values.
// A stalled output keeps its result; the earlier stages keep filling until full.
module incremental_pid_motor_drive_core
  import ipmd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [G_W-1:0]          cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [E_W-1:0]   in_encoder_count,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [DRV_W-1:0] out_drive_level,
  output logic [DUTY_W-1:0]       out_forward_duty,
  output logic [DUTY_W-1:0]       out_backward_duty
);

  ipmd_cfg_t  cfg;
  ipmd_prod_t prod;
  logic       prod_valid, prod_take;

  ipmd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ipmd_err_stage u_err (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_encoder_count (in_encoder_count),
    .prod_valid       (prod_valid),
    .prod             (prod),
    .prod_take        (prod_take)
  );

  ipmd_acc_stage u_acc (
    .clk               (clk),
    .rst_n             (rst_n),
    .prod_valid        (prod_valid),
    .prod              (prod),
    .prod_take         (prod_take),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_drive_level   (out_drive_level),
    .out_forward_duty  (out_forward_duty),
    .out_backward_duty (out_backward_duty)
  );

endmodule

// ----- tb/sv/tb_incremental_pid_motor_drive_core.sv -----
`timescale 1ns / 1ps

import ipmd_pkg::*;

// Predicts the drive for every encoder tick and checks results in order
class drive_scoreboard;
  typedef struct packed {
    logic signed [DRV_W-1:0] level;
    logic [DUTY_W-1:0]       fwd;
    logic [DUTY_W-1:0]       bwd;
  } drive_t;

  // Mirrored settings and controller state
  logic signed [E_W-1:0]   target;
  logic [G_W-1:0]          kp, ki, kd;
  logic signed [E_W-1:0]   err_last, err_prev;
  logic signed [DRV_W-1:0] drive_acc;

  drive_t pending_drive[$];
  int     mismatches;
  int     checked;
  int     ticks;

  function new();
    target     = TARGET_RESET;
    kp         = '0;
    ki         = '0;
    kd         = '0;
    err_last   = '0;
    err_prev   = '0;
    drive_acc  = '0;
    mismatches = 0;
    checked    = 0;
    ticks      = 0;
  endfunction

  function void write_reg(logic [IDX_W-1:0] idx, logic [G_W-1:0] data);
    case (idx)
      REG_TARGET_SPEED: target = data;
      REG_GAIN_P:       kp = data;
      REG_GAIN_I:       ki = data;
      REG_GAIN_D:       kd = data;
      default: ;
    endcase
  endfunction

  // One control tick: error, incremental PID step, clamped accumulate
  function void note_tick(logic signed [E_W-1:0] count);
    longint e, e1, e2, acc_sum, step, drv, neg;
    drive_t d;
    e1 = longint'(err_last);
    e2 = longint'(err_prev);
    e  = longint'(target) - longint'(count);
    if (e > 32767) e = 32767;
    if (e < -32768) e = -32768;
    acc_sum = longint'(kp) * (e - e1) + longint'(ki) * e
            + longint'(kd) * (e - 2 * e1 + e2);
    // shift with truncation toward zero
    if (acc_sum < 0) step = -((-acc_sum) >>> GAIN_FRAC_BITS);
    else             step = acc_sum >>> GAIN_FRAC_BITS;
    if (step > 32767) step = 32767;
    if (step < -32768) step = -32768;
    drv = longint'(drive_acc) + step;
    if (drv > DRIVE_LIMIT) drv = DRIVE_LIMIT;
    if (drv < -DRIVE_LIMIT) drv = -DRIVE_LIMIT;
    neg = -drv;
    d.level = drv[DRV_W-1:0];
    d.fwd   = (drv > 0) ? drv[DUTY_W-1:0] : '0;
    d.bwd   = (drv > 0) ? '0 : neg[DUTY_W-1:0];
    drive_acc = drv[DRV_W-1:0];
    err_prev  = err_last;
    err_last  = e[E_W-1:0];
    pending_drive.push_back(d);
    ticks++;
  endfunction

  function void check_drive(drive_t got);
    drive_t want;
    if (pending_drive.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected result level %0d fwd %0d bwd %0d", $realtime,
                 got.level, got.fwd, got.bwd);
      return;
    end
    want = pending_drive.pop_front();
    checked++;
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: mismatch exp level %0d fwd %0d bwd %0d, got level %0d fwd %0d bwd %0d",
                 $realtime, want.level, want.fwd, want.bwd, got.level, got.fwd, got.bwd);
    end
  endfunction

  function int outstanding();
    return pending_drive.size();
  endfunction
endclass

module tb_incremental_pid_motor_drive_core;

  localparam int PIPE_LAT = 3;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [IDX_W-1:0]        cfg_index = '0;
  logic [G_W-1:0]          cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [E_W-1:0]   in_encoder_count = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [DRV_W-1:0] out_drive_level;
  logic [DUTY_W-1:0]       out_forward_duty;
  logic [DUTY_W-1:0]       out_backward_duty;

  bit quiet = 1'b0;
  int n_settings = 0;
  drive_scoreboard sb = new();

  incremental_pid_motor_drive_core DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_encoder_count  (in_encoder_count),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_drive_level   (out_drive_level),
    .out_forward_duty  (out_forward_duty),
    .out_backward_duty (out_backward_duty)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Monitor: config writes, input and result transfers
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) sb.note_tick(in_encoder_count);
      if (out_valid && !out_stall)
        sb.check_drive({out_drive_level, out_forward_duty, out_backward_duty});
    end
  end

  // Receiver back-pressure in random bursts
  initial begin
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Present one count and hold it until the transfer
  task automatic send_tick(input logic signed [E_W-1:0] count);
    in_valid         <= 1'b1;
    in_encoder_count <= count;
    do @(posedge clk); while (in_stall);
  endtask

  // Random sender gap ahead of the next tick
  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // Stop sending and let every expected drive come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  // Write all four registers on consecutive cycles
  task automatic load_settings(input logic [G_W-1:0] tgt, input logic [G_W-1:0] gp,
                               input logic [G_W-1:0] gi, input logic [G_W-1:0] gd);
    cfg_we    <= 1'b1;
    cfg_index <= REG_TARGET_SPEED;
    cfg_data  <= tgt;
    @(posedge clk);
    cfg_index <= REG_GAIN_P;
    cfg_data  <= gp;
    @(posedge clk);
    cfg_index <= REG_GAIN_I;
    cfg_data  <= gi;
    @(posedge clk);
    cfg_index <= REG_GAIN_D;
    cfg_data  <= gd;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  function automatic logic [G_W-1:0] pick_gain();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return G_W'($urandom);
    return G_W'($urandom_range(0, 16'h0300));
  endfunction

  function automatic logic [G_W-1:0] pick_target();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h8000;
    if (r == 1) return 16'h7fff;
    if (r <= 4) return G_W'($urandom);
    return G_W'(int'($urandom_range(0, 400)) - 200);
  endfunction

  // Mostly counts near the target, some full range, some extremes
  function automatic logic signed [E_W-1:0] pick_count(input logic signed [E_W-1:0] tgt);
    int r, v;
    r = $urandom_range(0, 9);
    if (r < 7) begin
      v = int'(tgt) + int'($urandom_range(0, 128)) - 64;
      return v[E_W-1:0];
    end
    if (r < 9) return E_W'($urandom);
    case ($urandom_range(0, 3))
      0: return E_MIN;
      1: return E_MAX;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  // Run timeout
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [G_W-1:0] tgt;
    int n_items;
    int failures;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings, zero gains: drive stays zero, both duties zero
    send_tick(16'sd0);
    send_tick(E_MAX);
    send_tick(E_MIN);
    send_tick(-16'sd1);

    // Unity-ish gains near the target
    drain();
    load_settings(16'd100, 16'h0100, 16'h0080, 16'h0040);
    send_tick(16'sd100);
    send_tick(16'sd0);
    send_tick(16'sd50);
    send_tick(16'sd200);
    send_tick(-16'sd300);

    // Error saturation high, increment saturation, drive clamps at both ends
    drain();
    load_settings(16'h7fff, 16'hffff, 16'hffff, 16'hffff);
    send_tick(E_MIN);
    send_tick(E_MAX);
    send_tick(E_MIN);
    send_tick(16'sd0);

    // Error saturation low
    drain();
    load_settings(16'h8000, 16'hffff, 16'h0000, 16'hffff);
    send_tick(E_MAX);
    send_tick(E_MIN);
    send_tick(16'sd12345);
    send_tick(-16'sd1);

    // Truncation toward zero of small negative sums
    drain();
    load_settings(16'd0, 16'h0000, 16'h0001, 16'h0000);
    send_tick(16'sd1);
    send_tick(-16'sd1);
    send_tick(16'sd255);
    send_tick(-16'sd255);
    send_tick(16'sd257);
    send_tick(-16'sd257);

    // Random phases, the last two without idling
    for (int ph = 0; ph < 14; ph++) begin
      drain();
      quiet = (ph >= 12);
      tgt = pick_target();
      load_settings(tgt, pick_gain(), pick_gain(), pick_gain());
      n_items = $urandom_range(40, 60);
      for (int k = 0; k < n_items; k++) begin
        sender_gap();
        if (!quiet && $urandom_range(0, 99) == 0) drain();
        send_tick(pick_count(tgt));
      end
    end

    drain();
    failures = sb.mismatches + sb.outstanding();
    if (sb.outstanding() != 0)
      $display("%0d expected drive results never arrived", sb.outstanding());
    $display("covered %0d encoder ticks under %0d settings, %0d drive results compared",
             sb.ticks, n_settings, sb.checked);
    $display("%0d mismatches", sb.mismatches);
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
